[hdl/acu_pkg.sv]
`default_nettype none
package acu_pkg;

    // Largest access unit, in bytes, before a framing error is reported.
    localparam int MAX_AU_BYTES = 1048576;
    localparam int CNT_W        = $clog2(MAX_AU_BYTES + 2);
    localparam int NALS_W       = 19;
    localparam logic [NALS_W-1:0] NAL_MAX = '1;

    // Error codes reported with each access unit.
    typedef logic [3:0] t_err;
    localparam t_err ERR_OK    = 4'd0;
    localparam t_err ERR_FRAME = 4'd1;
    localparam t_err ERR_HDR   = 4'd2;
    localparam t_err ERR_LAYER = 4'd3;
    localparam t_err ERR_TRUNC = 4'd4;
    localparam t_err ERR_CRA   = 4'd5;
    localparam t_err ERR_TYPE  = 4'd6;
    localparam t_err ERR_PART  = 4'd7;
    localparam t_err ERR_PIC   = 4'd8;
    localparam t_err ERR_IDR   = 4'd9;
    localparam t_err ERR_PSET  = 4'd10;
    localparam t_err ERR_SEQ   = 4'd11;

    // One classified byte, passed from the front end to the checker.
    // win[0] is the oldest byte of the window, win[3] the byte just taken.
    typedef struct packed {
        logic [3:0][7:0] win;
        logic [1:0]      k_cl;      // unit position of win[3] byte, clipped at 3
        logic            start;
        logic            last;
        logic            hevc;
        logic            claims;
        logic [63:0]     seq;
        logic            oversize;
    } t_job;

endpackage
`default_nettype wire

[hdl/acu_front.sv]
`default_nettype none
module acu_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [7:0]      i_data,
    input  wire logic            i_first_byte,
    input  wire logic            i_last_byte,
    input  wire logic            i_is_hevc,
    input  wire logic            i_claims_idr,
    input  wire logic [63:0]     i_sequence_req,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output acu_pkg::t_job        o_job
);

    logic [2:0][7:0]             r_look;
    logic [acu_pkg::CNT_W-1:0]   r_count;
    logic                        r_idle;
    logic [acu_pkg::CNT_W-1:0]   cnt;
    logic [acu_pkg::CNT_W-1:0]   n_count;
    logic                        start;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // Position of this byte within the unit and the saturating byte count.
    always_comb begin
        start   = i_first_byte || r_idle;
        cnt     = start ? '0 : r_count;
        n_count = (cnt <= acu_pkg::CNT_W'(acu_pkg::MAX_AU_BYTES)) ? cnt + 1'b1 : cnt;
    end

    // Build the job that the checker consumes.
    always_comb begin
        o_job.win      = {i_data, r_look[2], r_look[1], r_look[0]};
        o_job.k_cl     = (cnt >= acu_pkg::CNT_W'(3)) ? 2'd3 : cnt[1:0];
        o_job.start    = start;
        o_job.last     = i_last_byte;
        o_job.hevc     = i_is_hevc;
        o_job.claims   = i_claims_idr;
        o_job.seq      = i_sequence_req;
        o_job.oversize = n_count > acu_pkg::CNT_W'(acu_pkg::MAX_AU_BYTES);
    end

    // Lookahead window and unit tracking advance on every transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_look  <= '0;
            r_count <= '0;
            r_idle  <= 1'b1;
        end else if (o_push) begin
            r_look  <= {i_data, r_look[2], r_look[1]};
            r_count <= n_count;
            r_idle  <= i_last_byte;
        end
    end

endmodule
`default_nettype wire

[hdl/acu_queue.sv]
`default_nettype none
module acu_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  acu_pkg::t_job        i_job,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output acu_pkg::t_job        o_job
);

    acu_pkg::t_job r_mem [4];
    logic [1:0]    r_wp;
    logic [1:0]    r_rp;
    logic [2:0]    r_cnt;

    assign o_full  = r_cnt == 3'd4;
    assign o_valid = r_cnt != 3'd0;
    assign o_job   = r_mem[r_rp];

    // Storage is written at the tail.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + {2'b0, i_push} - {2'b0, i_pop};
        end
    end

endmodule
`default_nettype wire

[hdl/acu_back.sv]
`default_nettype none
module acu_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  acu_pkg::t_job        i_job,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [3:0]           o_error,
    output logic [18:0]          o_nal_count,
    output logic [1:0]           o_picture_count,
    output logic                 o_has_vps,
    output logic                 o_has_sps,
    output logic                 o_has_pps,
    output logic                 o_has_idr,
    output logic                 o_has_vcl
);

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_START  = 4'b0010,
        PH_PREFIX = 4'b0100,
        PH_BODY   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [1:0]                   len;
        logic [2:0][7:0]              hdr;
        t_phase                       phase;
        acu_pkg::t_err                ferr;
        logic [4:0]                   flags;
        logic [1:0]                   pics;
        logic [acu_pkg::NALS_W-1:0]   nals;
    } t_pstate;

    localparam logic [4:0] F_VPS = 5'b00001;
    localparam logic [4:0] F_SPS = 5'b00010;
    localparam logic [4:0] F_PPS = 5'b00100;
    localparam logic [4:0] F_IDR = 5'b01000;
    localparam logic [4:0] F_VCL = 5'b10000;

    // Steps of one job: window position 0, positions 1 to 3 at the unit end,
    // the closing NAL and the unit verdict.
    localparam logic [2:0] S_POS0   = 3'd0;
    localparam logic [2:0] S_FINISH = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    // Checks a completed NAL header and collects its flags and counts.
    function automatic t_pstate finish_nal(t_pstate s, logic hevc);
        t_pstate    r;
        logic [5:0] t6;
        logic [4:0] t5;
        logic [4:0] add;
        logic       pic;
        logic       fail;
        r    = s;
        add  = '0;
        pic  = 1'b0;
        fail = 1'b1;
        t6   = s.hdr[0][6:1];
        t5   = s.hdr[0][4:0];
        if ((hevc && s.len < 2'd2) || (!hevc && s.len == 2'd0) || s.hdr[0][7]) begin
            r.ferr = acu_pkg::ERR_HDR;
        end else if (hevc) begin
            if (s.hdr[0][0] || s.hdr[1][7:3] != 5'd0 || s.hdr[1][2:0] == 3'd0) begin
                r.ferr = acu_pkg::ERR_LAYER;
            end else if (t6 <= 6'd31 && s.len < 2'd3) begin
                r.ferr = acu_pkg::ERR_TRUNC;
            end else if (t6 >= 6'd16 && t6 <= 6'd23 && t6 != 6'd19 && t6 != 6'd20) begin
                r.ferr = acu_pkg::ERR_CRA;
            end else begin
                fail = 1'b0;
                if (t6 <= 6'd31) begin
                    add = add | F_VCL;
                    pic = s.hdr[2][7];
                end
                if (t6 == 6'd32) add = add | F_VPS;
                if (t6 == 6'd33) add = add | F_SPS;
                if (t6 == 6'd34) add = add | F_PPS;
                if (t6 == 6'd19 || t6 == 6'd20) add = add | F_IDR;
            end
        end else begin
            if (t5 == 5'd0 || t5 >= 5'd24) begin
                r.ferr = acu_pkg::ERR_TYPE;
            end else if ((t5 == 5'd1 || t5 == 5'd5) && s.len < 2'd2) begin
                r.ferr = acu_pkg::ERR_TRUNC;
            end else if (t5 >= 5'd2 && t5 <= 5'd4) begin
                r.ferr = acu_pkg::ERR_PART;
            end else begin
                fail = 1'b0;
                if (t5 == 5'd1 || t5 == 5'd5) begin
                    add = add | F_VCL;
                    pic = s.hdr[1][7];
                end
                if (t5 == 5'd7) add = add | F_SPS;
                if (t5 == 5'd8) add = add | F_PPS;
                if (t5 == 5'd5) add = add | F_IDR;
            end
        end
        if (!fail) begin
            r.flags = s.flags | add;
            if (pic && s.pics < 2'd2) r.pics = s.pics + 1'b1;
            if (s.nals != acu_pkg::NAL_MAX) r.nals = s.nals + 1'b1;
        end
        return r;
    endfunction

    // Judges one window position: start code, prefix or NAL byte.
    function automatic t_pstate judge(t_pstate s, logic [3:0][7:0] w, logic [1:0] j,
                                      logic hevc);
        t_pstate    r;
        logic       sc3;
        logic       sc4;
        logic [1:0] plen;
        r    = s;
        sc3  = (j <= 2'd1) && w[j] == 8'd0 && w[j + 2'd1] == 8'd0 && w[j + 2'd2] == 8'd1;
        sc4  = (j == 2'd0) && w[0] == 8'd0 && w[1] == 8'd0 && w[2] == 8'd0 && w[3] == 8'd1;
        plen = sc3 ? 2'd2 : 2'd3;
        if (s.ferr != acu_pkg::ERR_OK) begin
            r = s;
        end else if (s.phase == PH_PREFIX) begin
            if (s.len != 2'd0) r.len = s.len - 1'b1;
            if (r.len == 2'd0) r.phase = PH_BODY;
        end else if (s.phase == PH_START) begin
            if (!(sc3 || sc4)) begin
                r.ferr = acu_pkg::ERR_FRAME;
            end else begin
                r.len   = plen;
                r.phase = PH_PREFIX;
            end
        end else if (sc3 || sc4) begin
            r = finish_nal(s, hevc);
            if (r.ferr == acu_pkg::ERR_OK) begin
                r.len   = plen;
                r.phase = PH_PREFIX;
            end
        end else if (s.len < 2'd3) begin
            r.hdr[s.len] = w[j];
            r.len        = s.len + 1'b1;
        end
        return r;
    endfunction

    t_pstate        r_ps;
    t_pstate        eff;
    t_pstate        n_ps;
    logic [2:0]     r_step;
    logic [2:0]     n_step;
    logic [63:0]    r_prev;
    logic           r_idr_need;
    logic           r_ov;
    logic [1:0]     jstart;
    logic           out_free;
    logic           advance;
    logic           load;
    acu_pkg::t_err  err;
    logic           idr;

    assign out_free = !r_ov || i_ready;
    assign advance  = i_q_valid && (r_step != S_RESULT || out_free);
    assign load     = advance && r_step == S_RESULT;
    assign o_pop    = advance && ((r_step == S_POS0 && !i_job.last) || r_step == S_RESULT);
    assign o_valid  = r_ov;

    // Unit state seen by this step; a new unit starts from cleared counters.
    always_comb begin
        eff = r_ps;
        if (r_step == S_POS0 && i_job.start) begin
            eff.len   = 2'd0;
            eff.phase = PH_START;
            eff.ferr  = acu_pkg::ERR_OK;
            eff.flags = '0;
            eff.pics  = '0;
            eff.nals  = '0;
        end
    end

    // One judgement or check per cycle; empty queue or held result stalls it.
    always_comb begin
        jstart = (i_job.k_cl == 2'd3) ? 2'd1 : 2'd3 - i_job.k_cl;
        n_ps   = eff;
        n_step = r_step + 1'b1;
        unique case (r_step)
            S_POS0: begin
                if (i_job.k_cl == 2'd3) n_ps = judge(eff, i_job.win, 2'd0, i_job.hevc);
                if (!i_job.last) n_step = S_POS0;
            end
            3'd1, 3'd2, 3'd3: begin
                if (r_step[1:0] >= jstart) begin
                    n_ps = judge(eff, i_job.win, r_step[1:0], i_job.hevc);
                end
            end
            S_FINISH: begin
                if (eff.ferr == acu_pkg::ERR_OK && eff.phase == PH_BODY) begin
                    n_ps = finish_nal(eff, i_job.hevc);
                end
            end
            S_RESULT: begin
                n_ps.phase = PH_IDLE;
                n_step     = S_POS0;
            end
            default: begin
                n_step = S_POS0;
            end
        endcase
    end

    // Unit verdict in priority order.
    always_comb begin
        idr = (r_ps.flags & F_IDR) != 5'd0;
        err = r_ps.ferr;
        if (i_job.oversize) begin
            err = acu_pkg::ERR_FRAME;
        end else if (err == acu_pkg::ERR_OK) begin
            priority if ((r_ps.flags & F_VCL) == 5'd0 || r_ps.pics != 2'd1
                         || idr != i_job.claims) begin
                err = acu_pkg::ERR_PIC;
            end else if (r_idr_need && !idr) begin
                err = acu_pkg::ERR_IDR;
            end else if (idr && ((r_ps.flags & F_SPS) == 5'd0 || (r_ps.flags & F_PPS) == 5'd0
                         || (i_job.hevc && (r_ps.flags & F_VPS) == 5'd0))) begin
                err = acu_pkg::ERR_PSET;
            end else if (i_job.seq != r_prev + 64'd1) begin
                err = acu_pkg::ERR_SEQ;
            end else begin
                err = acu_pkg::ERR_OK;
            end
        end
    end

    // Parser state and sequence history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps.len   <= '0;
            r_ps.phase <= PH_IDLE;
            r_ps.ferr  <= acu_pkg::ERR_OK;
            r_ps.flags <= '0;
            r_ps.pics  <= '0;
            r_ps.nals  <= '0;
            r_step     <= S_POS0;
            r_prev     <= '0;
            r_idr_need <= 1'b1;
        end else if (advance) begin
            r_ps.len   <= n_ps.len;
            r_ps.phase <= n_ps.phase;
            r_ps.ferr  <= n_ps.ferr;
            r_ps.flags <= n_ps.flags;
            r_ps.pics  <= n_ps.pics;
            r_ps.nals  <= n_ps.nals;
            r_step     <= n_step;
            if (load && err == acu_pkg::ERR_OK) begin
                r_prev     <= i_job.seq;
                r_idr_need <= 1'b0;
            end
        end
        if (advance) begin
            r_ps.hdr <= n_ps.hdr;
        end
    end

    // Result register; the next unit keeps parsing while it waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_error         <= err;
            o_nal_count     <= r_ps.nals;
            o_picture_count <= r_ps.pics;
            o_has_vps       <= r_ps.flags[0];
            o_has_sps       <= r_ps.flags[1];
            o_has_pps       <= r_ps.flags[2];
            o_has_idr       <= r_ps.flags[3];
            o_has_vcl       <= r_ps.flags[4];
        end
    end

endmodule
`default_nettype wire

[hdl/annexb_access_unit_checker_top.sv]
`default_nettype none
// Checks one H.264 or HEVC Annex-B access unit per run of bytes and returns one
// verdict transfer after the byte marked last. Bytes are taken one per cycle
// into a four-entry queue while it has room; the checker handles each ordinary
// byte at window position 0 and, on the last byte of a unit, also the three
// trailing window positions, the closing NAL and the unit verdict. The queue and
// the result register let input and output stall independently.
module annexb_access_unit_checker_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data,
    input  wire logic        i_first_byte,
    input  wire logic        i_last_byte,
    input  wire logic        i_is_hevc,
    input  wire logic        i_claims_idr,
    input  wire logic [63:0] i_sequence_req,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_error,
    output logic [18:0]      o_nal_count,
    output logic [1:0]       o_picture_count,
    output logic             o_has_vps,
    output logic             o_has_sps,
    output logic             o_has_pps,
    output logic             o_has_idr,
    output logic             o_has_vcl
);

    acu_pkg::t_job push_job;
    acu_pkg::t_job head_job;
    logic          push;
    logic          q_full;
    logic          q_valid;
    logic          pop;

    // Front end: lookahead window and byte position.
    acu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data         (i_data),
        .i_first_byte   (i_first_byte),
        .i_last_byte    (i_last_byte),
        .i_is_hevc      (i_is_hevc),
        .i_claims_idr   (i_claims_idr),
        .i_sequence_req (i_sequence_req),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_job          (push_job)
    );

    // Decoupling queue.
    acu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // Parser and unit checks.
    acu_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_job           (head_job),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_error         (o_error),
        .o_nal_count     (o_nal_count),
        .o_picture_count (o_picture_count),
        .o_has_vps       (o_has_vps),
        .o_has_sps       (o_has_sps),
        .o_has_pps       (o_has_pps),
        .o_has_idr       (o_has_idr),
        .o_has_vcl       (o_has_vcl)
    );

    // A reported code is always one of the defined errors.
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_error <= acu_pkg::ERR_SEQ)
        else $error("error code out of range");

    // A clean unit always holds exactly one picture with slice data.
    a_ok_pic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error == acu_pkg::ERR_OK) |-> (o_has_vcl && o_picture_count == 2'd1))
        else $error("clean unit without a single picture");

    // The picture count saturates at two.
    a_pic_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_picture_count != 2'd3)
        else $error("picture count beyond saturation");

endmodule
`default_nettype wire

[tb/tb_annexb_access_unit_checker_top.sv]
`timescale 1ns / 1ps
module tb_annexb_access_unit_checker_top;
    import acu_pkg::*;

    localparam int LIMIT_CYCLES = 8000000;

    typedef enum logic [1:0] {PH_IDLE, PH_START, PH_PREFIX, PH_BODY} parse_e;

    localparam logic [4:0] F_VPS = 5'd1;
    localparam logic [4:0] F_SPS = 5'd2;
    localparam logic [4:0] F_PPS = 5'd4;
    localparam logic [4:0] F_IDR = 5'd8;
    localparam logic [4:0] F_VCL = 5'd16;

    typedef struct packed {
        t_err        err;
        logic [18:0] nals;
        logic [1:0]  pics;
        logic        vps;
        logic        sps;
        logic        pps;
        logic        idr;
        logic        vcl;
    } verdict_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data = '0;
    logic        i_first_byte = 1'b0;
    logic        i_last_byte = 1'b0;
    logic        i_is_hevc = 1'b0;
    logic        i_claims_idr = 1'b0;
    logic [63:0] i_sequence_req = '0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [3:0]  o_error;
    logic [18:0] o_nal_count;
    logic [1:0]  o_picture_count;
    logic        o_has_vps;
    logic        o_has_sps;
    logic        o_has_pps;
    logic        o_has_idr;
    logic        o_has_vcl;

    annexb_access_unit_checker_top u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Model state of the checker.
    logic [7:0]  win_hist[3];
    int unsigned au_bytes;
    int          nal_len;
    logic [7:0]  hdr[3];
    parse_e      phase;
    t_err        unit_err;
    logic [4:0]  seen;
    logic [1:0]  pic_cnt;
    logic [18:0] nal_cnt;
    logic [63:0] last_seq;
    bit          need_idr;

    verdict_t    verdicts_due[$];
    int          fails = 0;
    int          verdicts_seen = 0;
    int unsigned cycles = 0;
    bit          calm = 1'b0;
    int          stall_left = 0;

    function automatic int start_code_len(logic [7:0] w[4], int j, int avail);
        if (avail >= 3 && w[j] == 8'h00 && w[j+1] == 8'h00 && w[j+2] == 8'h01)
            return 3;
        if (avail >= 4 && j == 0 && w[0] == 8'h00 && w[1] == 8'h00 && w[2] == 8'h00
            && w[3] == 8'h01)
            return 4;
        return 0;
    endfunction

    // Closes one NAL unit: header checks, then flags and counters.
    function void close_nal(bit hevc);
        logic [4:0] add;
        bit         pic;
        int         t;
        add = '0;
        pic = 1'b0;
        if (nal_len < (hevc ? 2 : 1) || hdr[0][7]) begin
            unit_err = ERR_HDR;
            return;
        end
        if (hevc) begin
            t = hdr[0][6:1];
            if (hdr[0][0] || hdr[1][7:3] != 0 || hdr[1][2:0] == 0) begin
                unit_err = ERR_LAYER;
                return;
            end
            if (t <= 31) begin
                if (nal_len < 3) begin
                    unit_err = ERR_TRUNC;
                    return;
                end
                add |= F_VCL;
                pic = hdr[2][7];
            end
            if (t >= 16 && t <= 23 && t != 19 && t != 20) begin
                unit_err = ERR_CRA;
                return;
            end
            if (t == 32) add |= F_VPS;
            if (t == 33) add |= F_SPS;
            if (t == 34) add |= F_PPS;
            if (t == 19 || t == 20) add |= F_IDR;
        end else begin
            t = hdr[0][4:0];
            if (t == 0 || t >= 24) begin
                unit_err = ERR_TYPE;
                return;
            end
            if (t == 1 || t == 5) begin
                if (nal_len < 2) begin
                    unit_err = ERR_TRUNC;
                    return;
                end
                add |= F_VCL;
                pic = hdr[1][7];
            end
            if (t >= 2 && t <= 4) begin
                unit_err = ERR_PART;
                return;
            end
            if (t == 7) add |= F_SPS;
            if (t == 8) add |= F_PPS;
            if (t == 5) add |= F_IDR;
        end
        seen |= add;
        if (pic && pic_cnt < 2) pic_cnt++;
        if (nal_cnt != NAL_MAX) nal_cnt++;
    endfunction

    // Judges one window position: start code, header byte or body byte.
    function void judge(logic [7:0] w[4], int j, int avail, bit hevc);
        int sc;
        if (unit_err != ERR_OK) return;
        if (phase == PH_PREFIX) begin
            if (nal_len > 0) nal_len--;
            if (nal_len == 0) phase = PH_BODY;
            return;
        end
        sc = start_code_len(w, j, avail);
        if (phase == PH_START) begin
            if (sc == 0) begin
                unit_err = ERR_FRAME;
                return;
            end
        end else if (sc != 0) begin
            close_nal(hevc);
            if (unit_err != ERR_OK) return;
        end else begin
            if (nal_len < 3) begin
                hdr[nal_len] = w[j];
                nal_len++;
            end
            return;
        end
        nal_len = sc - 1;
        phase = PH_PREFIX;
    endfunction

    function void model_reset();
        win_hist = '{default: 8'h00};
        hdr = '{default: 8'h00};
        au_bytes = 0;
        nal_len = 0;
        phase = PH_IDLE;
        unit_err = ERR_OK;
        seen = '0;
        pic_cnt = '0;
        nal_cnt = '0;
        last_seq = '0;
        need_idr = 1'b1;
    endfunction

    // Advances the model by one accepted byte and queues the verdict it causes.
    function void predict_byte(logic [7:0] d, bit first, bit last, bit hevc, bit claims,
                               logic [63:0] seq);
        logic [7:0]  w[4];
        int unsigned k;
        int          j;
        t_err        e;
        bit          idr;
        verdict_t    v;
        if (first || phase == PH_IDLE) begin
            au_bytes = 0;
            nal_len = 0;
            phase = PH_START;
            unit_err = ERR_OK;
            seen = '0;
            pic_cnt = '0;
            nal_cnt = '0;
        end
        k = au_bytes;
        if (au_bytes <= MAX_AU_BYTES) au_bytes++;
        w[0] = win_hist[0];
        w[1] = win_hist[1];
        w[2] = win_hist[2];
        w[3] = d;
        if (k >= 3) judge(w, 0, 4, hevc);
        win_hist[0] = win_hist[1];
        win_hist[1] = win_hist[2];
        win_hist[2] = d;
        if (!last) return;
        for (j = (k >= 3) ? 1 : 3 - k; j < 4; j++)
            judge(w, j, 4 - j, hevc);
        if (unit_err == ERR_OK && phase == PH_BODY) close_nal(hevc);
        e = unit_err;
        if (au_bytes > MAX_AU_BYTES) e = ERR_FRAME;
        if (e == ERR_OK) begin
            idr = (seen & F_IDR) != 0;
            if ((seen & F_VCL) == 0 || pic_cnt != 1 || idr != claims)
                e = ERR_PIC;
            else if (need_idr && !idr)
                e = ERR_IDR;
            else if (idr && ((seen & F_SPS) == 0 || (seen & F_PPS) == 0 ||
                             (hevc && (seen & F_VPS) == 0)))
                e = ERR_PSET;
            else if (seq != last_seq + 64'd1)
                e = ERR_SEQ;
        end
        if (e == ERR_OK) begin
            last_seq = seq;
            need_idr = 1'b0;
        end
        v.err  = e;
        v.nals = nal_cnt;
        v.pics = pic_cnt;
        v.vps  = (seen & F_VPS) != 0;
        v.sps  = (seen & F_SPS) != 0;
        v.pps  = (seen & F_PPS) != 0;
        v.idr  = (seen & F_IDR) != 0;
        v.vcl  = (seen & F_VCL) != 0;
        verdicts_due.push_back(v);
        phase = PH_IDLE;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sends one byte and waits for its transfer.
    task automatic send_byte(logic [7:0] d, bit first, bit last, bit hevc, bit claims,
                             logic [63:0] seq);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_data         <= d;
        i_first_byte   <= first;
        i_last_byte    <= last;
        i_is_hevc      <= hevc;
        i_claims_idr   <= claims;
        i_sequence_req <= seq;
        do @(posedge i_clk); while (!o_ready);
        predict_byte(d, first, last, hevc, claims, seq);
    endtask

    task automatic send_unit(logic [7:0] q[$], bit hevc, bit claims, logic [63:0] seq,
                             bit mark_first = 1'b1, bit mark_last = 1'b1);
        bit lst;
        foreach (q[i]) begin
            lst = mark_last && (i == q.size() - 1);
            send_byte(q[i], mark_first && i == 0, lst, hevc,
                      lst ? claims : bit'($urandom_range(0, 1)),
                      lst ? seq : {$urandom, $urandom});
        end
    endtask

    task automatic push_sc(ref logic [7:0] q[$], input bit long_sc);
        if (long_sc) q.push_back(8'h00);
        q.push_back(8'h00);
        q.push_back(8'h00);
        q.push_back(8'h01);
    endtask

    // Appends one NAL; the random payload bytes after the slice byte are never zero.
    task automatic push_nal(ref logic [7:0] q[$], input logic [7:0] h0, input logic [7:0] h1,
                            input bit hevc, input bit slice, input bit first_slice);
        int n;
        push_sc(q, $urandom_range(0, 1));
        q.push_back(h0);
        if (hevc) q.push_back(h1);
        if (slice) q.push_back({first_slice, 7'($urandom)});
        n = $urandom_range(0, 4);
        repeat (n) q.push_back(8'($urandom_range(1, 255)));
    endtask

    function automatic logic [7:0] h264_hdr(int t);
        return {1'b0, 2'($urandom), 5'(t)};
    endfunction

    function automatic logic [7:0] hevc_hdr0(int t);
        return {1'b0, 6'(t), 1'b0};
    endfunction

    function automatic logic [7:0] hevc_hdr1();
        return {5'd0, 3'($urandom_range(1, 7))};
    endfunction

    // Builds a well-formed unit, IDR or not, with optional SEI and parameter sets (always for IDR).
    task automatic build_unit(ref logic [7:0] q[$], input bit hevc, input bit idr);
        int t;
        if (hevc) begin
            if (idr || $urandom_range(0, 3) == 0) begin
                push_nal(q, hevc_hdr0(32), hevc_hdr1(), 1, 0, 0);
                push_nal(q, hevc_hdr0(33), hevc_hdr1(), 1, 0, 0);
                push_nal(q, hevc_hdr0(34), hevc_hdr1(), 1, 0, 0);
            end
            if ($urandom_range(0, 2) == 0)
                push_nal(q, hevc_hdr0(39), hevc_hdr1(), 1, 0, 0);
            t = idr ? $urandom_range(19, 20) : $urandom_range(0, 9);
            push_nal(q, hevc_hdr0(t), hevc_hdr1(), 1, 1, 1);
            if ($urandom_range(0, 3) == 0)
                push_nal(q, hevc_hdr0(t), hevc_hdr1(), 1, 1, 0);
        end else begin
            if (idr || $urandom_range(0, 3) == 0) begin
                push_nal(q, h264_hdr(7), 8'h00, 0, 0, 0);
                push_nal(q, h264_hdr(8), 8'h00, 0, 0, 0);
            end
            if ($urandom_range(0, 2) == 0)
                push_nal(q, h264_hdr(6), 8'h00, 0, 0, 0);
            t = idr ? 5 : 1;
            push_nal(q, h264_hdr(t), 8'h00, 0, 1, 1);
            if ($urandom_range(0, 3) == 0)
                push_nal(q, h264_hdr(t), 8'h00, 0, 1, 0);
        end
    endtask

    task automatic test_h264_good();
        logic [7:0] q[$];
        q = {8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h42, 8'h00, 8'h00, 8'h01, 8'h68, 8'hCE,
             8'h00, 8'h00, 8'h01, 8'h65, 8'h88, 8'hFF};
        send_unit(q, 0, 1, 64'd1);
        q = {8'h00, 8'h00, 8'h01, 8'h41, 8'h9A};
        send_unit(q, 0, 0, 64'd2);
    endtask

    task automatic test_hevc_good();
        logic [7:0] q[$];
        q = {8'h00, 8'h00, 8'h00, 8'h01, 8'h40, 8'h01, 8'h0C, 8'h00, 8'h00, 8'h01, 8'h42,
             8'h01, 8'h00, 8'h00, 8'h01, 8'h44, 8'h01, 8'h00, 8'h00, 8'h01, 8'h26, 8'h07,
             8'hAF};
        send_unit(q, 1, 1, 64'd3);
        // Two plain HEVC slices following on in sequence.
        q = {8'h00, 8'h00, 8'h01, 8'h02, 8'h01, 8'h80};
        send_unit(q, 1, 0, last_seq + 1);
        q = {8'h00, 8'h00, 8'h01, 8'h02, 8'h01, 8'h80};
        send_unit(q, 1, 0, last_seq + 1);
    endtask

    task automatic test_header_errors();
        logic [7:0] q[$];
        q = {8'h00, 8'h00, 8'h01, 8'hE5, 8'h80};          // forbidden bit
        send_unit(q, 0, 1, last_seq + 1);
        q = {8'h00, 8'h00, 8'h01, 8'h02};                 // HEVC header cut short
        send_unit(q, 1, 0, last_seq + 1);
        q = {8'h00, 8'h00, 8'h01, 8'h03, 8'h01, 8'h80};   // HEVC layer id
        send_unit(q, 1, 0, last_seq + 1);
        q = {8'h00, 8'h00, 8'h01, 8'h02, 8'h08, 8'h80};   // HEVC layer id, upper bits
        send_unit(q, 1, 0, last_seq + 1);
        q = {8'h00, 8'h00, 8'h01, 8'h02, 8'h00, 8'h80};   // temporal id zero
        send_unit(q, 1, 0, last_seq + 1);
        q = {8'h00, 8'h00, 8'h01, 8'h02, 8'h01};          // truncated HEVC slice
        send_unit(q, 1, 0, last_seq + 1);
        q = {8'h00, 8'h00, 8'h01, 8'h2A, 8'h01, 8'h80};   // CRA
        send_unit(q, 1, 0, last_seq + 1);
        q = {8'h00, 8'h00, 8'h01, 8'h60};                 // H.264 type zero
        send_unit(q, 0, 0, last_seq + 1);
        q = {8'h00, 8'h00, 8'h01, 8'h1F, 8'h11};          // H.264 type above 23
        send_unit(q, 0, 0, last_seq + 1);
        q = {8'h00, 8'h00, 8'h01, 8'h41, 8'h00, 8'h00, 8'h01, 8'h41, 8'h80};
        send_unit(q, 0, 0, last_seq + 1);                 // truncated H.264 slice
        q = {8'h00, 8'h00, 8'h01, 8'h22, 8'h80};          // data partitioning
        send_unit(q, 0, 0, last_seq + 1);
    endtask

    task automatic test_unit_checks();
        logic [7:0] q[$];
        q = {8'h00, 8'h00, 8'h01, 8'h41, 8'h80, 8'h00, 8'h00, 8'h01, 8'h41, 8'h80};
        send_unit(q, 0, 0, last_seq + 1);                 // two pictures
        q = {8'h00, 8'h00, 8'h01, 8'h65, 8'h80};
        send_unit(q, 0, 0, last_seq + 1);                 // IDR not claimed
        q = {8'h00, 8'h00, 8'h01, 8'h65, 8'h80};
        send_unit(q, 0, 1, last_seq + 1);                 // IDR without parameter sets
        q = {8'h00, 8'h00, 8'h01, 8'h41, 8'h80};
        send_unit(q, 0, 0, last_seq + 5);                 // discontinuity
        q = {8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h01, 8'h68, 8'h00, 8'h00,
             8'h01, 8'h65, 8'hFF};
        send_unit(q, 0, 1, last_seq + 1);
    endtask

    task automatic test_framing();
        logic [7:0] q[$];
        q = {8'h12, 8'h00, 8'h00, 8'h01, 8'h41, 8'h80};   // no leading start code
        send_unit(q, 0, 0, last_seq + 1);
        send_byte(8'hFF, 1, 1, 0, 0, last_seq + 1);       // single-byte unit
        send_byte(8'h00, 0, 1, 1, 1, '1);                 // idle byte without a first mark
        q = {8'h00, 8'h00, 8'h01, 8'h41};                 // left open and continued by the next bytes
        send_unit(q, 0, 0, 0, 1, 0);
        q = {8'h00, 8'h00, 8'h01, 8'h41, 8'h80};
        send_unit(q, 0, 0, last_seq + 1, 0, 1);           // continues the open unit without a first mark
        q = {8'h00, 8'h00, 8'h01};                        // start code only
        send_unit(q, 0, 0, last_seq + 1);
    endtask

    task automatic test_random();
        logic [7:0]  q[$];
        bit          hevc;
        bit          idr;
        bit          claims;
        bit          mark_first;
        bit          mark_last;
        logic [63:0] seq;
        int          n_bytes;
        int          i;
        n_bytes = 0;
        while (n_bytes < 230) begin
            calm = ($urandom_range(0, 5) == 0);
            q.delete();
            hevc = $urandom_range(0, 1);
            idr = need_idr ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 4) == 0);
            build_unit(q, hevc, idr);
            claims = idr;
            seq = last_seq + 1;
            mark_first = 1'b1;
            mark_last = 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 6))
                    0: begin
                        i = $urandom_range(0, q.size() - 1);
                        q[i] = q[i] ^ 8'($urandom_range(1, 255));
                    end
                    1: claims = !claims;
                    2: seq = {$urandom, $urandom};
                    3: mark_first = 1'b0;
                    4: mark_last = 1'b0;
                    5: q = q[0:$urandom_range(0, q.size() - 1)];
                    default: q.insert($urandom_range(0, q.size()), 8'h00);
                endcase
            end
            send_unit(q, hevc, claims, seq, mark_first, mark_last);
            n_bytes += q.size();
        end
        calm = 1'b0;
    endtask

    // Result side: random stalls, mostly short, and calm stretches.
    always @(posedge i_clk) begin
        if (calm) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 99) < 30) stall_left <= gap_len();
        end
    end

    // Checks each verdict transfer against the oldest prediction.
    always @(posedge i_clk) begin
        verdict_t v;
        if (i_rst_n && o_valid && i_ready) begin
            verdicts_seen++;
            if (verdicts_due.size() == 0) begin
                $error("verdict with none predicted: error %0d", o_error);
                fails++;
            end else begin
                v = verdicts_due.pop_front();
                if (o_error !== v.err) begin
                    $error("error: expected %0d, got %0d", v.err, o_error);
                    fails++;
                end
                if (o_nal_count !== v.nals) begin
                    $error("nal_count: expected %0d, got %0d", v.nals, o_nal_count);
                    fails++;
                end
                if (o_picture_count !== v.pics) begin
                    $error("picture_count: expected %0d, got %0d", v.pics, o_picture_count);
                    fails++;
                end
                if (o_has_vps !== v.vps) begin
                    $error("has_vps: expected %0d, got %0d", v.vps, o_has_vps);
                    fails++;
                end
                if (o_has_sps !== v.sps) begin
                    $error("has_sps: expected %0d, got %0d", v.sps, o_has_sps);
                    fails++;
                end
                if (o_has_pps !== v.pps) begin
                    $error("has_pps: expected %0d, got %0d", v.pps, o_has_pps);
                    fails++;
                end
                if (o_has_idr !== v.idr) begin
                    $error("has_idr: expected %0d, got %0d", v.idr, o_has_idr);
                    fails++;
                end
                if (o_has_vcl !== v.vcl) begin
                    $error("has_vcl: expected %0d, got %0d", v.vcl, o_has_vcl);
                    fails++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        model_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_h264_good();
        test_hevc_good();
        test_header_errors();
        test_unit_checks();
        test_framing();
        test_random();
        i_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/acu_pkg.sv
hdl/acu_front.sv
hdl/acu_queue.sv
hdl/acu_back.sv
hdl/annexb_access_unit_checker_top.sv
tb/tb_annexb_access_unit_checker_top.sv
